// ===== design/bgr_pkg.sv =====
// Shared types, constants and address helpers for the tile background renderer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package bgr_pkg;

  typedef enum logic [1:0] {
    ACT_TICK    = 2'd0,
    ACT_VRAM_WR = 2'd1,
    ACT_PAT_WR  = 2'd2,
    ACT_SCROLL  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    REG_CONTROL = 2'd0,
    REG_MASK    = 2'd1,
    REG_MIRROR  = 2'd2
  } cfg_reg_t;

  localparam int unsigned NAME_IDX_W    = 11;
  localparam int unsigned PATTERN_BYTES = 8192;
  localparam int unsigned PAT_AW        = $clog2(PATTERN_BYTES);

  localparam logic [13:0] NAME_BASE  = 14'h2000;
  localparam logic [13:0] ATTR_BASE  = 14'h23C0;
  localparam logic [13:0] NAME_END   = 14'h2FFF;
  localparam logic [13:0] PAL_BASE   = 14'h3F00;
  localparam logic [14:0] H_KEEP     = 15'h7BE0;
  localparam logic [14:0] H_BITS     = 15'h041F;
  localparam logic [14:0] NT_Y_FLIP  = 15'h0800;
  localparam logic [8:0]  DOTS       = 9'd341;
  localparam logic [8:0]  PRE_LINE   = 9'd261;
  localparam logic [8:0]  VBL_LINE   = 9'd241;
  localparam logic [8:0]  VIS_LINES  = 9'd240;

  typedef struct packed {
    logic                  en;
    logic [NAME_IDX_W-1:0] addr;
    logic [7:0]            data;
  } name_wr_t;

  typedef struct packed {
    logic                  en;
    logic [NAME_IDX_W-1:0] addr;
  } name_rd_t;

  function automatic logic [NAME_IDX_W-1:0] name_index(input logic [13:0] a,
                                                       input logic mirror);
    name_index = mirror ? {a[11], a[9:0]} : a[10:0];
  endfunction

  function automatic logic [4:0] palette_index(input logic [13:0] a);
    palette_index = (a[1:0] == 2'b00) ? {1'b0, a[3:0]} : a[4:0];
  endfunction

endpackage
`default_nettype wire

// ===== design/bgr_name_ram.sv =====
// Nametable RAM with registered read and a zero-fill sweep after reset.
// Depends on bgr_pkg for the read and write request structs.
`timescale 1ns / 1ps
`default_nettype none
module bgr_name_ram #(
  parameter int unsigned DEPTH = 2048
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire bgr_pkg::name_wr_t wr,
  input  wire bgr_pkg::name_rd_t rd,
  output logic [7:0]             rd_data,
  output logic                   busy
);
  import bgr_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  logic [7:0]  mem [DEPTH];
  logic [AW:0] clr_count;
  logic [AW:0] clr_count_next;

  assign busy           = (clr_count != DEPTH[AW:0]);
  assign clr_count_next = clr_count + {{AW{1'b0}}, 1'b1};

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_count <= '0;
    end else if (busy) begin
      clr_count <= clr_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_count[AW-1:0]] <= 8'h00;
    end else if (wr.en) begin
      mem[{{(AW-NAME_IDX_W){1'b0}}, wr.addr}] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[{{(AW-NAME_IDX_W){1'b0}}, rd.addr}];
    end
  end

endmodule
`default_nettype wire

// ===== design/bgr_pattern_ram.sv =====
// Pattern memory: one write port, one registered read port.
// Depends on bgr_pkg for its depth.
`timescale 1ns / 1ps
`default_nettype none
module bgr_pattern_ram (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [bgr_pkg::PAT_AW-1:0] wr_addr,
  input  wire logic [7:0]                 wr_data,
  input  wire logic                       rd_en,
  input  wire logic [bgr_pkg::PAT_AW-1:0] rd_addr,
  output logic [7:0]                      rd_data
);
  import bgr_pkg::*;

  logic [7:0] mem [PATTERN_BYTES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== design/tile_background_renderer_core.sv =====
// Tile background renderer top level: raster timing, scroll, fetch and pixel path.
// Depends on bgr_pkg, bgr_name_ram and bgr_pattern_ram.
`timescale 1ns / 1ps
`default_nettype none
// One beat in, one beat out, one beat per clock sustained while in_stall is low.
// Each beat is a dot tick, a memory write or a scroll load; the raster, scroll and
// shifter state update at the accept edge and the result beat lands in the output
// register. Memory reads of a fetch pass through the RAM's registered read port
// into the fetch latches, ahead of their use. After reset the nametable RAM is
// swept to zero with the input stalled; configuration writes are taken at any time.
module tile_background_renderer_core #(
  parameter int unsigned NAME_RAM_BYTES = 2048
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  action,
  input  wire logic [13:0] address,
  input  wire logic [7:0]  write_data,
  input  wire logic [14:0] scroll_temp,
  input  wire logic [2:0]  scroll_fine_x,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             pixel_valid,
  output logic [7:0]       pixel_x,
  output logic [7:0]       pixel_y,
  output logic [5:0]       color_index,
  output logic             nmi_pulse,
  output logic             vblank_flag
);
  import bgr_pkg::*;

  logic [7:0]  control_bits;
  logic [7:0]  mask_bits;
  logic        mirror_mode;
  logic [8:0]  dot_count, dot_count_next;
  logic [8:0]  line_count, line_count_next;
  logic        frame_parity, frame_parity_next;
  logic [14:0] vram_addr, vram_addr_next;
  logic [14:0] temp_addr, temp_addr_next;
  logic [2:0]  fine_x, fine_x_next;
  logic [7:0]  tile_id_latch;
  logic [1:0]  attr_latch;
  logic [7:0]  pat_lo, pat_hi;
  logic [15:0] shifters [4];
  logic [15:0] shifters_next [4];
  logic        vblank, vblank_next;
  logic [7:0]  palette_ram [32];

  logic        pend_tile, pend_attr, pend_lo, pend_hi;
  logic        pend_tile_next, pend_attr_next, pend_lo_next, pend_hi_next;
  logic [1:0]  attr_sel, attr_sel_next;

  logic        accept, name_busy;
  name_wr_t    name_wr;
  name_rd_t    name_rd;
  logic [7:0]  name_rd_data, pat_rd_data;
  logic        pat_wr_en, pat_rd_en;
  logic [PAT_AW-1:0] pat_rd_addr;
  logic        pal_wr_en;
  logic [4:0]  pal_wr_addr;

  logic        px_valid_next, nmi_next;
  logic [7:0]  px_x_next, px_y_next;
  logic [5:0]  color_next;

  logic        pre, render, render_line, fetch;
  logic [8:0]  dot, dot_inc;
  logic [2:0]  phase, fy;
  logic [4:0]  cy;
  logic [3:0]  bit_sel, choice;
  logic [13:0] tile_addr, attr_addr;
  logic [7:0]  attr_byte;

  assign cfg_ready = 1'b1;
  assign in_stall  = name_busy | (out_valid & out_stall);
  assign accept    = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      control_bits <= '0;
      mask_bits    <= '0;
      mirror_mode  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_CONTROL: control_bits <= cfg_data;
        REG_MASK:    mask_bits    <= cfg_data;
        REG_MIRROR:  mirror_mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign tile_addr = NAME_BASE | {2'b00, vram_addr[11:0]};
  assign attr_addr = ATTR_BASE | {2'b00, vram_addr[11:10], 4'h0, vram_addr[9:7],
                                  vram_addr[4:2]};

  always_comb begin
    pre         = (line_count == PRE_LINE);
    render      = |mask_bits[4:3];
    render_line = (line_count < VIS_LINES) || pre;
    dot         = (line_count == 9'd0 && dot_count == 9'd0) ? 9'd1 : dot_count;
    dot_inc     = dot + 9'd1;
    phase       = dot[2:0] - 3'd1;
    fetch       = render_line && ((dot >= 9'd2 && dot < 9'd258) ||
                                  (dot >= 9'd321 && dot < 9'd338));
    fy          = 3'd0;
    cy          = 5'd0;

    dot_count_next    = dot_count;
    line_count_next   = line_count;
    frame_parity_next = frame_parity;
    vram_addr_next    = vram_addr;
    temp_addr_next    = temp_addr;
    fine_x_next       = fine_x;
    vblank_next       = vblank;
    shifters_next     = shifters;
    pend_tile_next    = 1'b0;
    pend_attr_next    = 1'b0;
    pend_lo_next      = 1'b0;
    pend_hi_next      = 1'b0;
    attr_sel_next     = attr_sel;
    name_rd           = '0;
    name_wr           = '0;
    pat_rd_en         = 1'b0;
    pat_rd_addr       = '0;
    pat_wr_en         = 1'b0;
    pal_wr_en         = 1'b0;
    pal_wr_addr       = palette_index(address);
    px_valid_next     = 1'b0;
    px_x_next         = '0;
    px_y_next         = '0;
    color_next        = '0;
    nmi_next          = 1'b0;
    bit_sel           = {1'b1, ~fine_x};
    choice            = '0;

    if (accept) begin
      case (action_t'(action))
        ACT_TICK: begin
          if (render_line) begin
            if (pre && dot == 9'd1) begin
              vblank_next = 1'b0;
            end
            if (fetch) begin
              for (int i = 0; i < 4; i++) begin
                shifters_next[i] = {shifters[i][14:0], 1'b0};
              end
              case (phase)
                3'd0: begin
                  shifters_next[0][7:0] = pat_lo;
                  shifters_next[1][7:0] = pat_hi;
                  shifters_next[2][7:0] = {8{attr_latch[0]}};
                  shifters_next[3][7:0] = {8{attr_latch[1]}};
                  name_rd.en     = 1'b1;
                  name_rd.addr   = name_index(tile_addr, mirror_mode);
                  pend_tile_next = 1'b1;
                end
                3'd2: begin
                  name_rd.en     = 1'b1;
                  name_rd.addr   = name_index(attr_addr, mirror_mode);
                  pend_attr_next = 1'b1;
                  attr_sel_next  = {vram_addr[6], vram_addr[1]};
                end
                3'd4: begin
                  pat_rd_en    = 1'b1;
                  pat_rd_addr  = {control_bits[4], tile_id_latch, 1'b0, vram_addr[14:12]};
                  pend_lo_next = 1'b1;
                end
                3'd6: begin
                  pat_rd_en    = 1'b1;
                  pat_rd_addr  = {control_bits[4], tile_id_latch, 1'b1, vram_addr[14:12]};
                  pend_hi_next = 1'b1;
                end
                3'd7: begin
                  if (render) begin
                    if (vram_addr[4:0] == 5'd31) begin
                      vram_addr_next[4:0] = 5'd0;
                    end else begin
                      vram_addr_next = vram_addr + 15'd1;
                    end
                  end
                end
                default: ;
              endcase
            end
            if (dot == 9'd256 && render) begin
              fy = vram_addr_next[14:12];
              if (fy != 3'd7) begin
                vram_addr_next[14:12] = fy + 3'd1;
              end else begin
                vram_addr_next[14:12] = 3'd0;
                cy = vram_addr_next[9:5];
                if (cy == 5'd29) begin
                  cy             = 5'd0;
                  vram_addr_next = vram_addr_next ^ NT_Y_FLIP;
                end else if (cy == 5'd31) begin
                  cy = 5'd0;
                end else begin
                  cy = cy + 5'd1;
                end
                vram_addr_next[9:5] = cy;
              end
            end
            if (dot == 9'd257) begin
              shifters_next[0][7:0] = pat_lo;
              shifters_next[1][7:0] = pat_hi;
              shifters_next[2][7:0] = {8{attr_latch[0]}};
              shifters_next[3][7:0] = {8{attr_latch[1]}};
              if (render) begin
                vram_addr_next = (vram_addr_next & H_KEEP) | (temp_addr & H_BITS);
              end
            end
            if (dot == 9'd338 || dot == 9'd340) begin
              name_rd.en     = 1'b1;
              name_rd.addr   = name_index(tile_addr, mirror_mode);
              pend_tile_next = 1'b1;
            end
            if (pre && dot >= 9'd280 && dot < 9'd305 && render) begin
              vram_addr_next = (vram_addr_next & H_BITS) | (temp_addr & H_KEEP);
            end
          end

          if (line_count == VBL_LINE && dot == 9'd1) begin
            vblank_next = 1'b1;
            nmi_next    = control_bits[7];
          end

          if (mask_bits[3]) begin
            choice = {shifters_next[3][bit_sel], shifters_next[2][bit_sel],
                      shifters_next[1][bit_sel], shifters_next[0][bit_sel]};
          end
          if (line_count < VIS_LINES && dot >= 9'd1 && dot <= 9'd256) begin
            px_valid_next = 1'b1;
            px_x_next     = dot[7:0] - 8'd1;
            px_y_next     = line_count[7:0];
            color_next    = palette_ram[{1'b0, choice}][5:0];
          end

          dot_count_next = dot_inc;
          if (dot_inc >= DOTS || (frame_parity && pre && dot_inc == 9'd340 && render)) begin
            dot_count_next  = 9'd0;
            line_count_next = line_count + 9'd1;
            if (line_count_next == PRE_LINE) begin
              frame_parity_next = ~frame_parity;
            end
            if (line_count_next > PRE_LINE) begin
              line_count_next = 9'd0;
            end
          end
        end
        ACT_VRAM_WR: begin
          if (address >= NAME_BASE && address <= NAME_END) begin
            name_wr.en   = 1'b1;
            name_wr.addr = name_index(address, mirror_mode);
            name_wr.data = write_data;
          end else if (address >= PAL_BASE) begin
            pal_wr_en = 1'b1;
          end
        end
        ACT_PAT_WR: begin
          pat_wr_en = (address < NAME_BASE);
        end
        ACT_SCROLL: begin
          temp_addr_next = scroll_temp;
          fine_x_next    = scroll_fine_x;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    attr_byte = name_rd_data;
    if (attr_sel[1]) begin
      attr_byte = {4'h0, attr_byte[7:4]};
    end
    if (attr_sel[0]) begin
      attr_byte = {2'b00, attr_byte[7:2]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_count     <= '0;
      line_count    <= '0;
      frame_parity  <= 1'b0;
      vram_addr     <= '0;
      temp_addr     <= '0;
      fine_x        <= '0;
      vblank        <= 1'b0;
      tile_id_latch <= '0;
      attr_latch    <= '0;
      pat_lo        <= '0;
      pat_hi        <= '0;
      pend_tile     <= 1'b0;
      pend_attr     <= 1'b0;
      pend_lo       <= 1'b0;
      pend_hi       <= 1'b0;
      attr_sel      <= '0;
      for (int i = 0; i < 4; i++) begin
        shifters[i] <= '0;
      end
      for (int i = 0; i < 32; i++) begin
        palette_ram[i] <= '0;
      end
    end else begin
      dot_count    <= dot_count_next;
      line_count   <= line_count_next;
      frame_parity <= frame_parity_next;
      vram_addr    <= vram_addr_next;
      temp_addr    <= temp_addr_next;
      fine_x       <= fine_x_next;
      vblank       <= vblank_next;
      shifters     <= shifters_next;
      pend_tile    <= pend_tile_next;
      pend_attr    <= pend_attr_next;
      pend_lo      <= pend_lo_next;
      pend_hi      <= pend_hi_next;
      attr_sel     <= attr_sel_next;
      if (pend_tile) begin
        tile_id_latch <= name_rd_data;
      end
      if (pend_attr) begin
        attr_latch <= attr_byte[1:0];
      end
      if (pend_lo) begin
        pat_lo <= pat_rd_data;
      end
      if (pend_hi) begin
        pat_hi <= pat_rd_data;
      end
      if (pal_wr_en) begin
        palette_ram[pal_wr_addr] <= write_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pixel_valid <= px_valid_next;
      pixel_x     <= px_x_next;
      pixel_y     <= px_y_next;
      color_index <= color_next;
      nmi_pulse   <= nmi_next;
      vblank_flag <= vblank_next;
    end
  end

  bgr_name_ram #(
    .DEPTH(NAME_RAM_BYTES)
  ) u_name_ram (
    .clk     (clk),
    .rst     (rst),
    .wr      (name_wr),
    .rd      (name_rd),
    .rd_data (name_rd_data),
    .busy    (name_busy)
  );

  bgr_pattern_ram u_pattern_ram (
    .clk     (clk),
    .wr_en   (pat_wr_en),
    .wr_addr (address[PAT_AW-1:0]),
    .wr_data (write_data),
    .rd_en   (pat_rd_en),
    .rd_addr (pat_rd_addr),
    .rd_data (pat_rd_data)
  );

endmodule
`default_nettype wire

// ===== tb/bgr_checker.sv =====
// Checker for the tile background renderer: watches the register, item and pixel channels,
// runs its own raster/scroll/fetch model and compares every pixel beat.
// Depends on bgr_pkg for the action and register codes.
`timescale 1ns / 1ps
module bgr_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  action,
  input  logic [13:0] address,
  input  logic [7:0]  write_data,
  input  logic [14:0] scroll_temp,
  input  logic [2:0]  scroll_fine_x,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        pixel_valid,
  input  logic [7:0]  pixel_x,
  input  logic [7:0]  pixel_y,
  input  logic [5:0]  color_index,
  input  logic        nmi_pulse,
  input  logic        vblank_flag,
  output int          errors,
  output int          pending,
  output int          pixels_seen,
  output int          nmis_seen
);
  import bgr_pkg::*;

  typedef struct packed {
    logic       pv;
    logic [7:0] px;
    logic [7:0] py;
    logic [5:0] ci;
    logic       nmi;
    logic       vb;
  } pixel_beat_t;

  pixel_beat_t expected_pixels[$];

  logic [7:0]  ctrl_r, mask_r;
  logic        mirror_r;
  int unsigned dot_q, line_q;
  logic        odd_q, vbl_q;
  logic [14:0] v_q, t_q;
  logic [2:0]  fx_q;
  logic [7:0]  tile_q, plo_q, phi_q;
  logic [1:0]  attr_q;
  logic [15:0] sh[4];
  logic [7:0]  nt_mem[2048];
  logic [7:0]  pal_mem[32];
  logic [7:0]  pat_mem[8192];

  function automatic logic render_on();
    return mask_r[3] | mask_r[4];
  endfunction

  function automatic logic [10:0] nt_slot(input logic [13:0] a);
    return mirror_r ? {a[11], a[9:0]} : a[10:0];
  endfunction

  function automatic logic [4:0] pal_slot(input logic [13:0] a);
    return (a[1:0] == 2'b00) ? {1'b0, a[3:0]} : a[4:0];
  endfunction

  function automatic void reload_shifters();
    sh[0] = {sh[0][15:8], plo_q};
    sh[1] = {sh[1][15:8], phi_q};
    sh[2] = {sh[2][15:8], {8{attr_q[0]}}};
    sh[3] = {sh[3][15:8], {8{attr_q[1]}}};
  endfunction

  function automatic void fetch_step(input int unsigned d);
    logic [4:0]  cx, cy;
    logic [2:0]  fy;
    logic [13:0] a;
    logic [7:0]  b;
    cx = v_q[4:0];
    cy = v_q[9:5];
    fy = v_q[14:12];
    for (int i = 0; i < 4; i++) sh[i] = sh[i] << 1;
    case ((d - 1) & 7)
      0: begin
        reload_shifters();
        tile_q = nt_mem[nt_slot({2'b10, v_q[11:0]})];
      end
      2: begin
        a = 14'h23C0 | {2'b00, v_q[11:10], 10'b0} | ({9'b0, cy[4:2]} << 3) | {11'b0, cx[4:2]};
        b = nt_mem[nt_slot(a)];
        if (cy[1]) b = b >> 4;
        if (cx[1]) b = b >> 2;
        attr_q = b[1:0];
      end
      4: plo_q = pat_mem[{ctrl_r[4], tile_q, 1'b0, fy}];
      6: phi_q = pat_mem[{ctrl_r[4], tile_q, 1'b1, fy}];
      7: if (render_on()) begin
        if (cx == 5'd31) v_q = v_q & 15'h7FE0;
        else v_q = v_q + 15'd1;
      end
      default: ;
    endcase
  endfunction

  function automatic void step_fine_y();
    logic [4:0] cy;
    if (v_q[14:12] != 3'd7) begin
      v_q[14:12] = v_q[14:12] + 3'd1;
      return;
    end
    v_q[14:12] = 3'd0;
    cy = v_q[9:5];
    if (cy == 5'd29) begin
      cy = 5'd0;
      v_q[11] = ~v_q[11];
    end else if (cy == 5'd31) cy = 5'd0;
    else cy = cy + 5'd1;
    v_q[9:5] = cy;
  endfunction

  function automatic pixel_beat_t render_dot();
    pixel_beat_t r;
    logic        pre;
    int unsigned d, nd, bitpos;
    logic [3:0]  choice;
    r = '0;
    pre = (line_q == 261);
    if (line_q == 0 && dot_q == 0) dot_q = 1;
    d = dot_q;
    if (line_q < 240 || pre) begin
      if (pre && d == 1) vbl_q = 1'b0;
      if ((d >= 2 && d < 258) || (d >= 321 && d < 338)) fetch_step(d);
      if (d == 256 && render_on()) step_fine_y();
      if (d == 257) begin
        reload_shifters();
        if (render_on()) v_q = (v_q & 15'h7BE0) | (t_q & 15'h041F);
      end
      if (d == 338 || d == 340) tile_q = nt_mem[nt_slot({2'b10, v_q[11:0]})];
      if (pre && d >= 280 && d < 305 && render_on())
        v_q = (v_q & 15'h041F) | (t_q & 15'h7BE0);
    end
    if (line_q == 241 && d == 1) begin
      vbl_q = 1'b1;
      r.nmi = ctrl_r[7];
    end
    choice = '0;
    if (mask_r[3]) begin
      bitpos = 15 - fx_q;
      choice = {sh[3][bitpos], sh[2][bitpos], sh[1][bitpos], sh[0][bitpos]};
    end
    if (line_q < 240 && d >= 1 && d <= 256) begin
      r.pv = 1'b1;
      r.px = 8'(d - 1);
      r.py = 8'(line_q);
      r.ci = pal_mem[pal_slot({10'h3F0, choice})][5:0];
    end
    nd = d + 1;
    dot_q = nd;
    if (nd >= 341 || (odd_q && pre && nd == 340 && render_on())) begin
      dot_q = 0;
      line_q++;
      if (line_q == 261) odd_q = ~odd_q;
      if (line_q > 261) line_q = 0;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    pixel_beat_t got, exp_beat;
    if (rst) begin
      ctrl_r = '0; mask_r = '0; mirror_r = 1'b0;
      dot_q = 0; line_q = 0; odd_q = 1'b0; vbl_q = 1'b0;
      v_q = '0; t_q = '0; fx_q = '0; tile_q = '0; attr_q = '0; plo_q = '0; phi_q = '0;
      for (int i = 0; i < 4; i++) sh[i] = '0;
      for (int i = 0; i < 2048; i++) nt_mem[i] = '0;
      for (int i = 0; i < 32; i++) pal_mem[i] = '0;
      for (int i = 0; i < 8192; i++) pat_mem[i] = '0;
      expected_pixels.delete();
      errors = 0; pixels_seen = 0; nmis_seen = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_CONTROL: ctrl_r = cfg_data;
          REG_MASK:    mask_r = cfg_data;
          REG_MIRROR:  mirror_r = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = '{pixel_valid, pixel_x, pixel_y, color_index, nmi_pulse, vblank_flag};
        if (expected_pixels.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected pixel beat %p", got);
        end else begin
          exp_beat = expected_pixels.pop_front();
          if (got.pv !== exp_beat.pv || got.px !== exp_beat.px || got.py !== exp_beat.py ||
              got.ci !== exp_beat.ci || got.nmi !== exp_beat.nmi || got.vb !== exp_beat.vb) begin
            errors++;
            if (errors <= 10) $display("pixel mismatch exp %p got %p", exp_beat, got);
          end
          pixels_seen += got.pv;
          nmis_seen += got.nmi;
        end
      end
      if (in_valid && !in_stall) begin
        exp_beat = '0;
        case (action_t'(action))
          ACT_TICK: exp_beat = render_dot();
          ACT_VRAM_WR: begin
            if (address >= 14'h2000 && address <= 14'h2FFF) nt_mem[nt_slot(address)] = write_data;
            else if (address >= 14'h3F00) pal_mem[pal_slot(address)] = write_data;
          end
          ACT_PAT_WR: if (address < 14'h2000) pat_mem[address[12:0]] = write_data;
          default: begin
            t_q = scroll_temp;
            fx_q = scroll_fine_x;
          end
        endcase
        exp_beat.vb = vbl_q;
        expected_pixels.push_back(exp_beat);
      end
    end
    pending = expected_pixels.size();
  end

endmodule

// ===== tb/tb.sv =====
// Top of the background renderer testbench: clock, reset, register writes, item and
// pixel-side stimulus with idle bursts, and the final verdict.
// Depends on bgr_pkg, tile_background_renderer_core and bgr_checker.
`timescale 1ns / 1ps
module tb;
  import bgr_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  action = '0;
  logic [13:0] address = '0;
  logic [7:0]  write_data = '0;
  logic [14:0] scroll_temp = '0;
  logic [2:0]  scroll_fine_x = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        pixel_valid, nmi_pulse, vblank_flag;
  logic [7:0]  pixel_x, pixel_y;
  logic [5:0]  color_index;

  int  errors, pending, pixels_seen, nmis_seen;
  int  beats_sent = 0;
  int  cycles = 0;
  bit  quiet = 1'b0;
  bit  held = 1'b0;

  tile_background_renderer_core DUT (.*);

  bgr_checker checker_i (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if (!rst && !held && beats_sent > 600) begin
        out_stall = 1'b1;
        repeat (400) @(negedge clk);
        out_stall = 1'b0;
        held = 1'b1;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 17)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  task automatic send_beat(input action_t act, input logic [13:0] a, input logic [7:0] d,
                           input logic [14:0] st, input logic [2:0] fx);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 9) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid = 1'b1;
    action = act;
    address = a;
    write_data = d;
    scroll_temp = st;
    scroll_fine_x = fx;
    do @(posedge clk); while (in_stall);
    beats_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [7:0] d);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = d;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // keep nametable bytes below 16 so every tile fetch lands in the preloaded patterns
  task automatic random_beats(input int n);
    int r;
    logic [13:0] a;
    logic [7:0]  d;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 65) send_beat(ACT_TICK, 14'($urandom), 8'($urandom), 15'($urandom), 3'($urandom));
      else if (r < 85) begin
        case ($urandom_range(0, 3))
          0, 1: a = 14'h2000 | 14'($urandom_range(0, 14'hFFF));
          2: a = 14'h3F00 | 14'($urandom_range(0, 8'hFF));
          default: a = 14'($urandom);
        endcase
        if (a >= 14'h2000 && a <= 14'h2FFF) d = 8'($urandom_range(0, 15));
        else d = 8'($urandom);
        send_beat(ACT_VRAM_WR, a, d, 15'($urandom), 3'($urandom));
      end else if (r < 90)
        send_beat(ACT_PAT_WR, 14'($urandom), 8'($urandom), 15'($urandom), 3'($urandom));
      else send_beat(ACT_SCROLL, 14'($urandom), 8'($urandom), 15'($urandom), 3'($urandom));
    end
  endtask

  task automatic tick_run(input int n);
    for (int i = 0; i < n; i++) send_beat(ACT_TICK, '0, '0, '0, '0);
  endtask

  task automatic set_phase(input logic [7:0] c, input logic [7:0] m, input logic mir);
    wait_drained();
    write_reg(REG_CONTROL, c);
    write_reg(REG_MASK, m);
    write_reg(REG_MIRROR, {7'b0, mir});
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    set_phase(8'h00, 8'h00, 1'b0);
    // preload every pattern byte of tiles 0 to 15 in both table halves
    for (int i = 0; i < 512; i++)
      send_beat(ACT_PAT_WR, 14'(((i >> 8) << 12) | (i & 255)), 8'($urandom), '0, '0);
    send_beat(ACT_VRAM_WR, 14'h2000, 8'h0F, '0, '0);
    send_beat(ACT_VRAM_WR, 14'h2FFF, 8'h0A, '0, '0);
    send_beat(ACT_VRAM_WR, 14'h1FFF, 8'h11, '0, '0);
    send_beat(ACT_VRAM_WR, 14'h3000, 8'h22, '0, '0);
    send_beat(ACT_VRAM_WR, 14'h3EFF, 8'h33, '0, '0);
    send_beat(ACT_VRAM_WR, 14'h3F00, 8'h3F, '0, '0);
    send_beat(ACT_VRAM_WR, 14'h3F10, 8'h15, '0, '0);
    send_beat(ACT_VRAM_WR, 14'h3FFF, 8'hFF, '0, '0);
    send_beat(ACT_VRAM_WR, 14'h23C0, 8'h0E, '0, '0);
    send_beat(ACT_PAT_WR, 14'h2000, 8'h44, '0, '0);
    send_beat(ACT_PAT_WR, 14'h3FFF, 8'h55, '0, '0);
    send_beat(ACT_PAT_WR, 14'h0000, 8'h00, '0, '0);
    send_beat(ACT_SCROLL, '0, '0, 15'h7FFF, 3'd7);
    send_beat(ACT_SCROLL, '0, '0, 15'h0000, 3'd0);
    send_beat(ACT_SCROLL, '0, '0, 15'h03A0, 3'd3);
    tick_run(6);
    random_beats(150);

    set_phase(8'h90, 8'h18, 1'b1);
    for (int i = 0; i < 32; i++) send_beat(ACT_VRAM_WR, 14'h3F00 | 14'(i), 8'($urandom), '0, '0);
    random_beats(150);
    tick_run(200);

    set_phase(8'hFF, 8'h10, 1'b0);
    random_beats(100);
    tick_run(60);

    set_phase(8'h7F, 8'hFF, 1'b1);
    quiet = 1'b1;
    random_beats(100);
    tick_run(40);

    wait_drained();
    repeat (20) @(posedge clk);
    $display("covered %0d beats over four register settings: %0d pixels, %0d vblank NMIs",
             beats_sent, pixels_seen, nmis_seen);
    if (errors == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule

// ===== tile_background_renderer_core.f =====
design/bgr_pkg.sv
design/bgr_name_ram.sv
design/bgr_pattern_ram.sv
design/tile_background_renderer_core.sv
tb/bgr_checker.sv
tb/tb.sv
